@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_RST(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every rising clock edge.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/eikug_pkg.sv @@
package eikug_pkg;

  localparam int DIMS     = 3;
  localparam int VAL_W    = 24;
  localparam int PAIRS    = DIMS * (DIMS - 1) / 2;
  localparam int SUM_W    = VAL_W + $clog2(DIMS + 1);
  localparam int SQ_W     = 2 * VAL_W;
  localparam int DISC_W   = SQ_W + 2;
  localparam int ROOT_W   = DISC_W / 2;
  localparam int NUM_W    = ((SUM_W > ROOT_W) ? SUM_W : ROOT_W) + 1;
  localparam int FB_W     = VAL_W + 1;
  localparam int RECIP_SH = NUM_W + 3;
  localparam int PROD_W   = NUM_W + RECIP_SH;

  typedef logic [VAL_W-1:0] val_t;

  localparam val_t UNREACHED  = '1;
  localparam val_t MAX_FINITE = {{(VAL_W-1){1'b1}}, 1'b0};
  localparam val_t COST_RESET = VAL_W'(256);

  // ceil(2^RECIP_SH / DIMS): exact floor division for NUM_W-bit numerators
  localparam logic [RECIP_SH-1:0] RECIP =
    RECIP_SH'(((64'd1 << RECIP_SH) + 64'(DIMS) - 64'd1) / 64'(DIMS));

  // side info carried alongside the square root
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [FB_W-1:0]  fb;
    logic             fallback;
  } tag_t;

endpackage

@@ rtl/eikug_lane.sv @@
// One axis: pick the nearer neighbor, registered.
module eikug_lane import eikug_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  val_t lo_i,
  input  val_t hi_i,
  output val_t m_o
);

  val_t m_q, m_d;

  assign m_d = (lo_i < hi_i) ? lo_i : hi_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q <= m_d;
    end
  end

  assign m_o = m_q;

endmodule

@@ rtl/eikug_isqrt.sv @@
`include "assert_macros.svh"
// Pipelined integer square root, one result bit per stage.
module eikug_isqrt import eikug_pkg::*; #(
  parameter int TAG_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [DISC_W-1:0] x_i,
  input  logic [TAG_W-1:0]  tag_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_o,
  output logic [TAG_W-1:0]  tag_o
);

  localparam int REM_W = ROOT_W + 2;

  logic [ROOT_W:0]   vld_q;
  logic [DISC_W-1:0] x_q    [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W+1];
  logic [REM_W-1:0]  rem_q  [ROOT_W+1];
  logic [TAG_W-1:0]  tag_q  [ROOT_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[ROOT_W-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= x_i;
      root_q[0] <= '0;
      rem_q[0]  <= '0;
      tag_q[0]  <= tag_i;
    end
  end

  for (genvar k = 1; k <= ROOT_W; k++) begin : g_stage
    logic [REM_W-1:0] rem_sh, trial;
    logic             ge;

    assign rem_sh = {rem_q[k-1][REM_W-3:0], x_q[k-1][2*(ROOT_W-k)+1 -: 2]};
    assign trial  = {root_q[k-1], 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[k] <= {root_q[k-1][ROOT_W-2:0], ge};
        rem_q[k]  <= ge ? (rem_sh - trial) : rem_sh;
        tag_q[k]  <= tag_q[k-1];
      end
    end

    // the last stage has no further use for the radicand
    if (k < ROOT_W) begin : g_x
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          x_q[k] <= x_q[k-1];
        end
      end
    end
  end

  assign valid_o = vld_q[ROOT_W];
  assign root_o  = root_q[ROOT_W];
  assign tag_o   = tag_q[ROOT_W];

  // exact floor sqrt leaves a remainder no larger than twice the root
  `ASSERT_RST(a_rem_bound, clk_i, rst_ni,
              valid_o |-> (rem_q[ROOT_W] <= {1'b0, root_o, 1'b0}),
              "isqrt remainder exceeds 2*root")

endmodule

@@ rtl/eikonal_grid_update.sv @@
// Channel  | Dir | Handshake               | Payload
// in       | in  | in_valid_i / in_stall_o | axis{0,1,2}_{low,high}_i
// out      | out | out_valid_o/out_stall_i | new_value_o, fallback_taken_o
// cfg      | in  | cfg_valid_i/cfg_ready_o | cfg_step_cost_i
//
// One request per cycle sustained while the output is not stalled; most of the
// pipe depth is the 25-stage square-root pipeline (one root bit per stage).
// All stages advance together; a stalled result at the output freezes the
// whole pipe and in_stall_o goes high in the same cycle.
// Reset clears valid bits and loads step_cost with 1.0 (256).
// cfg_ready_o is always high; writes are expected only while the pipe is empty.
`include "assert_macros.svh"
module eikonal_grid_update import eikug_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  val_t axis0_low_i,
  input  val_t axis0_high_i,
  input  val_t axis1_low_i,
  input  val_t axis1_high_i,
  input  val_t axis2_low_i,
  input  val_t axis2_high_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output val_t new_value_o,
  output logic fallback_taken_o,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  val_t cfg_step_cost_i
);

  logic en;
  val_t cost_q;

  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cost_q <= COST_RESET;
    end else if (cfg_valid_i) begin
      cost_q <= cfg_step_cost_i;
    end
  end

  // ---- stage 1: per-axis minimum in parallel lanes
  val_t lo_in [DIMS];
  val_t hi_in [DIMS];
  val_t lane_m [DIMS];
  logic s1_vld_q;

  assign lo_in[0] = axis0_low_i;
  assign hi_in[0] = axis0_high_i;
  assign lo_in[1] = axis1_low_i;
  assign hi_in[1] = axis1_high_i;
  assign lo_in[2] = axis2_low_i;
  assign hi_in[2] = axis2_high_i;

  for (genvar i = 0; i < DIMS; i++) begin : g_lane
    eikug_lane u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .lo_i  (lo_in[i]),
      .hi_i  (hi_in[i]),
      .m_o   (lane_m[i])
    );
  end

  // ---- stage 2: merge lanes: sum, min, unreached, pairwise differences
  logic             s2_vld_q, s2_unr_q, s2_unr_d;
  logic [SUM_W-1:0] s2_sum_q, s2_sum_d;
  logic [FB_W-1:0]  s2_fb_q;
  val_t             s2_cost_q, min_d;
  val_t             s2_dif_q [PAIRS];
  val_t             dif_d    [PAIRS];

  always_comb begin
    s2_sum_d = '0;
    min_d    = UNREACHED;
    s2_unr_d = 1'b0;
    for (int i = 0; i < DIMS; i++) begin
      s2_sum_d = s2_sum_d + SUM_W'(lane_m[i]);
      if (lane_m[i] < min_d) min_d = lane_m[i];
      if (lane_m[i] == UNREACHED) s2_unr_d = 1'b1;
    end
  end

  for (genvar i = 0; i < DIMS; i++) begin : g_pi
    for (genvar j = i + 1; j < DIMS; j++) begin : g_pj
      localparam int P = i * DIMS - (i * (i + 1)) / 2 + (j - i - 1);
      assign dif_d[P] = (lane_m[i] > lane_m[j]) ? (lane_m[i] - lane_m[j])
                                                : (lane_m[j] - lane_m[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_sum_q  <= s2_sum_d;
      s2_unr_q  <= s2_unr_d;
      s2_fb_q   <= FB_W'(min_d) + FB_W'(cost_q);
      s2_cost_q <= cost_q;
      s2_dif_q  <= dif_d;
    end
  end

  // ---- stage 3: squares
  logic            s3_vld_q;
  logic [SQ_W-1:0] s3_sq_q [PAIRS];
  logic [SQ_W-1:0] s3_c2_q;
  tag_t            s3_tag_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int p = 0; p < PAIRS; p++) begin
        s3_sq_q[p] <= SQ_W'(s2_dif_q[p]) * SQ_W'(s2_dif_q[p]);
      end
      s3_c2_q           <= SQ_W'(s2_cost_q) * SQ_W'(s2_cost_q);
      s3_tag_q.sum      <= s2_sum_q;
      s3_tag_q.fb       <= s2_fb_q;
      s3_tag_q.fallback <= s2_unr_q;
    end
  end

  // ---- stage 4: discriminant D*C^2 - sum of squared differences
  logic [DISC_W-1:0] pairs_d, dc2_d;
  tag_t              sq_tag;

  always_comb begin
    pairs_d = '0;
    dc2_d   = '0;
    for (int p = 0; p < PAIRS; p++) pairs_d = pairs_d + DISC_W'(s3_sq_q[p]);
    for (int i = 0; i < DIMS; i++) dc2_d = dc2_d + DISC_W'(s3_c2_q);
    sq_tag          = s3_tag_q;
    sq_tag.fallback = s3_tag_q.fallback || (pairs_d > dc2_d);
  end

  logic              sq_vld;
  logic [ROOT_W-1:0] sq_root;
  tag_t              sq_tag_o;

  eikug_isqrt #(.TAG_W($bits(tag_t))) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s3_vld_q),
    .x_i     (dc2_d - pairs_d),
    .tag_i   (sq_tag),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .tag_o   (sq_tag_o)
  );

  // ---- stage 5: (sum + root) * reciprocal of D
  logic              s5_vld_q;
  logic [PROD_W-1:0] s5_prod_q;
  tag_t              s5_tag_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_prod_q <= PROD_W'(NUM_W'(sq_tag_o.sum) + NUM_W'(sq_root)) * PROD_W'(RECIP);
      s5_tag_q  <= sq_tag_o;
    end
  end

  // ---- output: pick root or fallback, saturate
  logic [NUM_W-1:0] quot;
  val_t             res_d, new_value_q;
  logic             out_vld_q, fallback_q;

  assign quot = s5_prod_q[RECIP_SH +: NUM_W];

  always_comb begin
    if (s5_tag_q.fallback) begin
      res_d = (s5_tag_q.fb > FB_W'(MAX_FINITE)) ? MAX_FINITE : VAL_W'(s5_tag_q.fb);
    end else begin
      res_d = (quot > NUM_W'(MAX_FINITE)) ? MAX_FINITE : VAL_W'(quot);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      new_value_q <= res_d;
      fallback_q  <= s5_tag_q.fallback;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q  <= in_valid_i;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      s5_vld_q  <= sq_vld;
      out_vld_q <= s5_vld_q;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign new_value_o      = new_value_q;
  assign fallback_taken_o = fallback_q;

  `ASSERT_RST(a_no_unreached_out, clk_i, rst_ni,
              out_valid_o |-> (new_value_o != UNREACHED),
              "result carries the unreached code")
  `ASSERT_RST(a_freeze, clk_i, rst_ni,
              (out_valid_o && out_stall_i) |=> ($stable(s2_vld_q) && $stable(s5_vld_q)),
              "pipe moved while output stalled")

endmodule

@@ sim/eikonal_grid_update_checker.sv @@
module eikonal_grid_update_checker import eikug_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_stall_i,
  input  val_t axis0_low_i,
  input  val_t axis0_high_i,
  input  val_t axis1_low_i,
  input  val_t axis1_high_i,
  input  val_t axis2_low_i,
  input  val_t axis2_high_i,
  input  logic out_valid_i,
  input  logic out_stall_i,
  input  val_t new_value_i,
  input  logic fallback_taken_i,
  input  logic cfg_valid_i,
  input  logic cfg_ready_i,
  input  val_t cfg_step_cost_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   updates_seen_o,
  output int   fallbacks_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    val_t arrival;
    logic fallback;
  } arrival_t;

  val_t     cost_q;
  arrival_t arrival_q[$];

  function automatic logic [63:0] isqrt128(logic [127:0] x);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (128'(t) * 128'(t) <= x) r = t;
    end
    return r;
  endfunction

  function automatic arrival_t solve_arrival(val_t c, val_t a0l, val_t a0h, val_t a1l,
                                             val_t a1h, val_t a2l, val_t a2h);
    logic [63:0]  m[3];
    logic [63:0]  minv, total, d, u;
    logic [127:0] dc2, pairs;
    logic         blocked;
    arrival_t     res;
    m[0] = (a0l < a0h) ? a0l : a0h;
    m[1] = (a1l < a1h) ? a1l : a1h;
    m[2] = (a2l < a2h) ? a2l : a2h;
    minv = 64'(UNREACHED);
    total = '0;
    blocked = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (m[i] == 64'(UNREACHED)) blocked = 1'b1;
      if (m[i] < minv) minv = m[i];
      total += m[i];
    end
    if (!blocked) begin
      dc2 = 128'(3) * 128'(c) * 128'(c);
      pairs = '0;
      for (int i = 0; i < 3; i++)
        for (int j = i + 1; j < 3; j++) begin
          d = (m[i] > m[j]) ? m[i] - m[j] : m[j] - m[i];
          pairs += 128'(d) * 128'(d);
        end
      if (pairs <= dc2) begin
        u = (total + isqrt128(dc2 - pairs)) / 3;
        res.arrival = (u > 64'(MAX_FINITE)) ? MAX_FINITE : val_t'(u);
        res.fallback = 1'b0;
        return res;
      end
    end
    u = minv + 64'(c);
    res.arrival = (u > 64'(MAX_FINITE)) ? MAX_FINITE : val_t'(u);
    res.fallback = 1'b1;
    return res;
  endfunction

  assign pending_o = arrival_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    arrival_t want;
    if (!rst_ni) begin
      cost_q <= COST_RESET;
      arrival_q.delete();
      fail_count_o <= 0;
      updates_seen_o <= 0;
      fallbacks_seen_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) cost_q <= cfg_step_cost_i;
      if (in_valid_i && !in_stall_i)
        arrival_q.insert(arrival_q.size(),
                         solve_arrival(cost_q, axis0_low_i, axis0_high_i, axis1_low_i,
                                       axis1_high_i, axis2_low_i, axis2_high_i));
      if (out_valid_i && !out_stall_i) begin
        updates_seen_o <= updates_seen_o + 1;
        if (fallback_taken_i) fallbacks_seen_o <= fallbacks_seen_o + 1;
        if (arrival_q.size() == 0) begin
          if (fail_count_o < 10) $display("ERROR: unexpected update %h", new_value_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = arrival_q.pop_front();
          if (want.arrival !== new_value_i || want.fallback !== fallback_taken_i) begin
            if (fail_count_o < 10)
              $display("ERROR: value exp %h got %h, fallback exp %b got %b",
                       want.arrival, new_value_i, want.fallback, fallback_taken_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

@@ sim/eikonal_grid_update_tb.sv @@
module eikonal_grid_update_tb;
  import eikug_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // pipe is 31 deep; allow slack after the last update
  localparam int DRAIN_CYCLES = 40;
  localparam int WATCHDOG     = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  val_t axis0_low_i = '0, axis0_high_i = '0, axis1_low_i = '0;
  val_t axis1_high_i = '0, axis2_low_i = '0, axis2_high_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  val_t new_value_o;
  logic fallback_taken_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  val_t cfg_step_cost_i = '0;

  int fail_count, pending, updates_seen, fallbacks_seen;
  int idle_cycles = 0;
  bit calm;        // no idling in the closing stretch

  always #4 clk_i = ~clk_i;

  eikonal_grid_update uut (.*);

  eikonal_grid_update_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o),
    .axis0_low_i, .axis0_high_i, .axis1_low_i, .axis1_high_i,
    .axis2_low_i, .axis2_high_i,
    .out_valid_i(out_valid_o), .out_stall_i, .new_value_i(new_value_o),
    .fallback_taken_i(fallback_taken_o), .cfg_valid_i, .cfg_ready_i(cfg_ready_o),
    .cfg_step_cost_i, .fail_count_o(fail_count), .pending_o(pending),
    .updates_seen_o(updates_seen), .fallbacks_seen_o(fallbacks_seen)
  );

  // Watchdog: cycles with no request or update moved
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Timeout: pipe stopped moving");
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver back-pressure in bursts
  initial begin
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Random arrival: mostly near a common front so the quadratic path fires
  function automatic val_t pick_arrival(val_t base);
    case ($urandom_range(0, 9))
      0:       return UNREACHED;
      1:       return val_t'($urandom);
      2:       return MAX_FINITE;
      3:       return val_t'($urandom_range(0, 3));
      default: return base + val_t'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic send_request(val_t a, val_t b, val_t c, val_t d, val_t e, val_t f);
    bit held;
    axis0_low_i <= a; axis0_high_i <= b; axis1_low_i <= c;
    axis1_high_i <= d; axis2_low_i <= e; axis2_high_i <= f;
    in_valid_i <= 1'b1;
    // stall is settled mid-cycle; take its value ahead of the edge
    do begin
      @(negedge clk_i);
      held = in_stall_o;
      @(posedge clk_i);
    end while (held);
    // sender gap, never in the closing stretch
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  task automatic send_random;
    val_t base;
    base = val_t'($urandom_range(0, 24'hFF_F000));
    if ($urandom_range(0, 7) == 0) base = 24'hFF_FC00;
    send_request(pick_arrival(base), pick_arrival(base), pick_arrival(base),
                 pick_arrival(base), pick_arrival(base), pick_arrival(base));
  endtask

  // Empty the pipe and wait it out, as load_cost does before loading a new cost
  task automatic drain_pipe;
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_cost(val_t c);
    drain_pipe();
    cfg_step_cost_i <= c;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    val_t costs[6];
    costs = '{24'd0, 24'd256, 24'hFF_FFFE, 24'hFF_FFFF, 24'd1, 24'd4096};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset cost (1.0)
    send_request('0, '0, '0, '0, '0, '0);                          // all at origin
    send_request(24'd100, 24'd200, 24'd100, 24'd300, 24'd100, 24'd50);
    send_request(UNREACHED, UNREACHED, UNREACHED, UNREACHED, UNREACHED, UNREACHED);
    send_request(24'd10, UNREACHED, UNREACHED, UNREACHED, 24'd10, 24'd12); // one axis unreached
    send_request('0, 24'd5, 24'd2000, 24'd3000, 24'd10, 24'd11);    // negative discriminant
    send_request(MAX_FINITE, MAX_FINITE, MAX_FINITE, MAX_FINITE, MAX_FINITE, MAX_FINITE);
    send_request(24'hFF_FF00, 24'hFF_FFF0, 24'hFF_FF80, 24'hFF_FFF0, 24'hFF_FF40, MAX_FINITE);
    send_request(24'h55_5555, 24'hAA_AAAA, 24'h55_5555, 24'hAA_AAAA, 24'h55_5555, 24'hAA_AAAA);
    // Cost extremes, including the all-ones code
    load_cost(24'hFF_FFFF);
    send_request('0, '0, '0, '0, '0, '0);
    send_request(24'h00_0001, 24'hFF_0000, 24'd7, 24'd8, 24'd9, 24'd3);
    load_cost(24'd0);
    send_request(24'd500, 24'd600, 24'd500, 24'd700, 24'd500, 24'd900); // zero disc
    send_request(24'd500, 24'd600, 24'd501, 24'd700, 24'd500, 24'd900); // just negative

    // Random phases over a sweep of cost settings
    for (int p = 0; p < 8; p++) begin
      load_cost((p < 6) ? costs[p] : val_t'($urandom));
      if (p == 7) calm = 1'b1;
      repeat (100) send_random();
    end

    drain_pipe();
    $display("Covered %0d updates (%0d fallbacks): directed corners plus eight random",
             updates_seen, fallbacks_seen);
    $display("phases over step costs from zero to the all-ones code");
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
